>>> src/wdc_pkg.sv
// shared types, constants and opcode decode for the 65c816 predecoder
package wdc_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned ADDR_W = 24;
	localparam int unsigned LEN_W  = 3;
	localparam int unsigned MODE_W = 5;
	localparam int unsigned OPND_W = 24;

	localparam logic [7:0] M_BIT  = 8'h20;
	localparam logic [7:0] X_BIT  = 8'h10;
	localparam logic [7:0] OP_REP = 8'hC2;
	localparam logic [7:0] OP_SEP = 8'hE2;

	typedef enum logic [MODE_W-1:0] {
		AM_IMPLIED       = 5'd0,
		AM_ACCUM         = 5'd1,
		AM_IMM           = 5'd2,
		AM_DP            = 5'd3,
		AM_DP_X          = 5'd4,
		AM_DP_IND        = 5'd5,
		AM_DP_IND_LONG   = 5'd6,
		AM_DP_IND_LONG_Y = 5'd7,
		AM_DP_IND_Y      = 5'd8,
		AM_DP_X_IND      = 5'd9,
		AM_ABS           = 5'd10,
		AM_LONG          = 5'd11,
		AM_ABS_X         = 5'd12,
		AM_ABS_Y         = 5'd13,
		AM_SR            = 5'd14,
		AM_SR_IND_Y      = 5'd15,
		AM_REL           = 5'd16,
		AM_REL_LONG      = 5'd17
	} mode_t;

	typedef struct packed {
		mode_t            mode;
		logic [LEN_W-1:0] len;
	} dec_t;

	typedef struct packed {
		logic [ADDR_W-1:0] instr_address;
		logic [BYTE_W-1:0] opcode_value;
		logic [MODE_W-1:0] addressing_mode;
		logic [LEN_W-1:0]  instr_length;
		logic [OPND_W-1:0] operand_value;
		logic [ADDR_W-1:0] branch_target;
		logic              truncated;
		logic              accum_narrow;
		logic              index_narrow;
	} instr_t;

	function automatic dec_t decode_op(input logic [7:0] op, input logic m_nar,
		input logic x_nar);
		dec_t d;
		d.mode = AM_IMPLIED;
		d.len  = 3'd1;
		case (op) inside
			8'h0A, 8'h4A, 8'h2A: begin
				d.mode = AM_ACCUM; d.len = 3'd1;
			end
			8'h21, 8'h41, 8'h01: begin
				d.mode = AM_DP_X_IND; d.len = 3'd2;
			end
			8'h00, 8'hC2, 8'hE2: begin
				d.mode = AM_IMM; d.len = 3'd2;
			end
			8'hA9, 8'h69, 8'hE9, 8'hC9, 8'h29, 8'h49, 8'h09: begin
				d.mode = AM_IMM; d.len = m_nar ? 3'd2 : 3'd3;
			end
			8'hA2, 8'hA0, 8'hE0, 8'hC0: begin
				d.mode = AM_IMM; d.len = x_nar ? 3'd2 : 3'd3;
			end
			8'h10, 8'h30, 8'h50, 8'h70, 8'h90, 8'hB0, 8'hD0, 8'hF0, 8'h80: begin
				d.mode = AM_REL; d.len = 3'd2;
			end
			8'h82: begin
				d.mode = AM_REL_LONG; d.len = 3'd3;
			end
			8'hA5, 8'h85, 8'hA6, 8'hA4, 8'h65, 8'hE5,
			8'h25, 8'h45, 8'h05, 8'h06, 8'h46, 8'h26: begin
				d.mode = AM_DP; d.len = 3'd2;
			end
			8'hB5, 8'h95, 8'h75, 8'hF5, 8'h35,
			8'h55, 8'h15, 8'h16, 8'h56, 8'h36: begin
				d.mode = AM_DP_X; d.len = 3'd2;
			end
			8'hAD, 8'h8D, 8'h6D, 8'hED, 8'h20, 8'h2D,
			8'h4D, 8'h0D, 8'h0E, 8'h4E, 8'h2E: begin
				d.mode = AM_ABS; d.len = 3'd3;
			end
			8'h22: begin
				d.mode = AM_LONG; d.len = 3'd4;
			end
			8'hBD, 8'h9D, 8'h7D, 8'hFD, 8'h3D,
			8'h5D, 8'h1D, 8'h1E, 8'h5E, 8'h3E: begin
				d.mode = AM_ABS_X; d.len = 3'd3;
			end
			8'hB9, 8'h99, 8'h79, 8'hF9, 8'h39, 8'h59, 8'h19: begin
				d.mode = AM_ABS_Y; d.len = 3'd3;
			end
			8'hB2, 8'h92, 8'h72, 8'hF2, 8'h32, 8'h52, 8'h12: begin
				d.mode = AM_DP_IND; d.len = 3'd2;
			end
			8'h07, 8'hA7, 8'h87, 8'h27, 8'h47: begin
				d.mode = AM_DP_IND_LONG; d.len = 3'd2;
			end
			8'hB7, 8'h97, 8'h37, 8'h57, 8'h17: begin
				d.mode = AM_DP_IND_LONG_Y; d.len = 3'd2;
			end
			8'hB1, 8'h91, 8'h31, 8'h51, 8'h11: begin
				d.mode = AM_DP_IND_Y; d.len = 3'd2;
			end
			8'hA3, 8'h83, 8'hC3: begin
				d.mode = AM_SR; d.len = 3'd2;
			end
			8'hB3, 8'h93: begin
				d.mode = AM_SR_IND_Y; d.len = 3'd2;
			end
			default: begin
				d.mode = AM_IMPLIED; d.len = 3'd1;
			end
		endcase
		return d;
	endfunction

endpackage

>>> src/wdc_code_if.sv
// code byte channel
interface wdc_code_if import wdc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] code_byte;
	logic              last_byte;

	modport source (output valid, output code_byte, output last_byte, input ready);
	modport sink (input valid, input code_byte, input last_byte, output ready);
endinterface

>>> src/wdc_instr_if.sv
// decoded instruction channel
interface wdc_instr_if import wdc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] instr_address;
	logic [BYTE_W-1:0] opcode_value;
	logic [MODE_W-1:0] addressing_mode;
	logic [LEN_W-1:0]  instr_length;
	logic [OPND_W-1:0] operand_value;
	logic [ADDR_W-1:0] branch_target;
	logic              truncated;
	logic              accum_narrow;
	logic              index_narrow;

	modport source (output valid, output instr_address, output opcode_value,
		output addressing_mode, output instr_length, output operand_value,
		output branch_target, output truncated, output accum_narrow,
		output index_narrow, input ready);
	modport sink (input valid, input instr_address, input opcode_value,
		input addressing_mode, input instr_length, input operand_value,
		input branch_target, input truncated, input accum_narrow,
		input index_narrow, output ready);
endinterface

>>> src/wdc_cfg_if.sv
// base address write channel
interface wdc_cfg_if import wdc_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] base_address;

	modport source (output valid, output base_address, input ready);
	modport sink (input valid, input base_address, output ready);
endinterface

>>> src/wdc816_instruction_predecoder_core.sv
// 65c816 instruction predecoder top level
//
// code_bytes takes one code byte per word, last_byte marking the end of a
// section. instrs gives one word per finished instruction: address, opcode,
// addressing mode, length, operand, branch target, truncated flag and the
// m/x width flags after the instruction. cfg writes the base address of a
// section; write it only while no byte or instruction is in flight.
// a byte in the input register that finishes an instruction has its result
// written into the result register. throughput: one byte per cycle while
// no finishing byte waits on a stalled receiver; the decode table, operand
// merge and the branch target add sit between the two registers.
// reset: base address 0, awaiting an opcode, m and x clear (16-bit).
// a stalled receiver holds the result register; bytes that finish no
// instruction keep flowing, and a byte that finishes one waits in the input
// register until the result register frees.
module wdc816_instruction_predecoder_core import wdc_pkg::*; #(
	parameter int unsigned ADDRESS_BITS = 24
) (
	input logic         clk,
	input logic         arst_n,
	wdc_code_if.sink    code_bytes,
	wdc_instr_if.source instrs,
	wdc_cfg_if.sink     cfg
);

	localparam int unsigned AW = ADDRESS_BITS;

	// input register
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              last_s1;

	// decoder state
	logic [ADDR_W-1:0] base_q;
	logic [AW-1:0]     next_q;
	logic [AW-1:0]     start_q;
	logic [BYTE_W-1:0] opcode_q;
	mode_t             mode_q;
	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  seen_q;
	logic [OPND_W-1:0] opnd_q;
	logic              m_q;
	logic              x_q;

	// result register
	logic   out_valid_q;
	instr_t out_q;

	logic              out_free;
	logic              adv_s1;
	logic              first;
	dec_t              dec;
	logic [AW-1:0]     start_d;
	logic [BYTE_W-1:0] opcode_d;
	mode_t             mode_d;
	logic [LEN_W-1:0]  len_d;
	logic [LEN_W-1:0]  seen_d;
	logic [OPND_W-1:0] opnd_d;
	logic              done;
	logic              emit;
	logic              m_d;
	logic              x_d;
	logic [AW-1:0]     off;
	logic [AW-1:0]     target;
	instr_t            res;

	assign out_free        = !out_valid_q || instrs.ready;
	assign adv_s1          = !emit || out_free;
	assign code_bytes.ready = !valid_s1 || adv_s1;
	assign cfg.ready       = 1'b1;

	assign first = (seen_q == '0);
	assign dec   = decode_op(byte_s1, m_q, x_q);

	always_comb begin
		start_d  = start_q;
		opcode_d = opcode_q;
		mode_d   = mode_q;
		len_d    = len_q;
		opnd_d   = opnd_q;
		if (first) begin
			start_d  = next_q;
			opcode_d = byte_s1;
			mode_d   = dec.mode;
			len_d    = dec.len;
			opnd_d   = '0;
			seen_d   = 3'd1;
			done     = (dec.len <= 3'd1);
		end else begin
			case (seen_q)
				3'd1:    opnd_d[7:0]   = byte_s1;
				3'd2:    opnd_d[15:8]  = byte_s1;
				3'd3:    opnd_d[23:16] = byte_s1;
				default: opnd_d        = opnd_q;
			endcase
			seen_d = seen_q + 3'd1;
			done   = (seen_d >= len_q);
		end
		emit = valid_s1 && (done || last_s1);
	end

	// width flags after this instruction
	always_comb begin
		m_d = m_q;
		x_d = x_q;
		if (opcode_d == OP_SEP) begin
			if ((opnd_d[7:0] & M_BIT) != '0) m_d = 1'b1;
			if ((opnd_d[7:0] & X_BIT) != '0) x_d = 1'b1;
		end else if (opcode_d == OP_REP) begin
			if ((opnd_d[7:0] & M_BIT) != '0) m_d = 1'b0;
			if ((opnd_d[7:0] & X_BIT) != '0) x_d = 1'b0;
		end
	end

	// branch target
	always_comb begin
		if (mode_d == AM_REL_LONG) begin
			off = AW'($signed(opnd_d[15:0]));
		end else begin
			off = AW'($signed(opnd_d[7:0]));
		end
		if (mode_d == AM_REL || mode_d == AM_REL_LONG) begin
			target = start_d + AW'(len_d) + off;
		end else begin
			target = '0;
		end
	end

	always_comb begin
		res.instr_address   = ADDR_W'(start_d);
		res.opcode_value    = opcode_d;
		res.addressing_mode = mode_d;
		res.instr_length    = len_d;
		res.operand_value   = opnd_d;
		res.branch_target   = ADDR_W'(target);
		res.truncated       = !done;
		res.accum_narrow    = m_d;
		res.index_narrow    = x_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (code_bytes.ready) begin
			valid_s1 <= code_bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (code_bytes.ready && code_bytes.valid) begin
			byte_s1 <= code_bytes.code_byte;
			last_s1 <= code_bytes.last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			next_q   <= '0;
			start_q  <= '0;
			opcode_q <= '0;
			mode_q   <= AM_IMPLIED;
			len_q    <= '0;
			seen_q   <= '0;
			opnd_q   <= '0;
			m_q      <= 1'b0;
			x_q      <= 1'b0;
		end else if (cfg.valid) begin
			base_q <= cfg.base_address;
			next_q <= AW'(cfg.base_address);
		end else if (valid_s1 && adv_s1) begin
			start_q  <= start_d;
			opcode_q <= opcode_d;
			mode_q   <= mode_d;
			len_q    <= len_d;
			opnd_q   <= opnd_d;
			if (emit) begin
				m_q <= m_d;
				x_q <= x_d;
			end
			seen_q <= (emit || last_s1) ? '0 : seen_d;
			next_q <= last_s1 ? AW'(base_q) : next_q + AW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && emit) begin
			out_q <= res;
		end
	end

	assign instrs.valid           = out_valid_q;
	assign instrs.instr_address   = out_q.instr_address;
	assign instrs.opcode_value    = out_q.opcode_value;
	assign instrs.addressing_mode = out_q.addressing_mode;
	assign instrs.instr_length    = out_q.instr_length;
	assign instrs.operand_value   = out_q.operand_value;
	assign instrs.branch_target   = out_q.branch_target;
	assign instrs.truncated       = out_q.truncated;
	assign instrs.accum_narrow    = out_q.accum_narrow;
	assign instrs.index_narrow    = out_q.index_narrow;

	// a partial instruction never holds all of its bytes
	a_seen_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q != '0 |-> (seen_q < len_q && len_q >= 3'd2))
		else $error("byte count reached instruction length without a result");

	// a byte waiting in the input register is never dropped
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1 && $stable(byte_s1) && $stable(last_s1))
		else $error("stalled code byte lost");

	// a cut-off instruction always has operand bytes still missing
	a_trunc_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.truncated |-> out_q.instr_length >= 3'd2)
		else $error("single-byte instruction marked truncated");

	// only a finishing byte can stall the input side
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !code_bytes.ready |-> emit && out_valid_q && !instrs.ready)
		else $error("input stalled without a pending result");

endmodule

>>> tb/wdc816_instruction_predecoder_core_tb.sv
// self-checking testbench for the 65c816 instruction predecoder core
`timescale 1ns / 1ps

module wdc816_instruction_predecoder_core_tb;
	import wdc_pkg::*;

	localparam logic [7:0] OP_BRK     = 8'h00;
	localparam logic [7:0] OP_ASL_A   = 8'h0A;
	localparam logic [7:0] OP_JSL     = 8'h22;
	localparam logic [7:0] OP_BRA     = 8'h80;
	localparam logic [7:0] OP_BRL     = 8'h82;
	localparam logic [7:0] OP_LDY_IMM = 8'hA0;
	localparam logic [7:0] OP_LDX_IMM = 8'hA2;
	localparam logic [7:0] OP_LDA_IMM = 8'hA9;
	localparam logic [7:0] OP_CMP_IMM = 8'hC9;
	localparam logic [7:0] OP_BEQ     = 8'hF0;
	localparam logic [7:0] OP_UNLISTED = 8'hFF;

	typedef struct packed {
		logic [BYTE_W-1:0] b;
		logic              last;
	} code_word_t;

	logic clk;
	logic arst_n;

	wdc_code_if  code_ch ();
	wdc_instr_if instr_ch ();
	wdc_cfg_if   cfg_ch ();

	wdc816_instruction_predecoder_core #(.ADDRESS_BITS(ADDR_W)) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.code_bytes (code_ch),
		.instrs     (instr_ch),
		.cfg        (cfg_ch)
	);

	// decoder shadow state
	logic [ADDR_W-1:0] base_addr  = '0;
	logic [ADDR_W-1:0] next_addr  = '0;
	logic [ADDR_W-1:0] ins_addr   = '0;
	logic [BYTE_W-1:0] ins_op     = '0;
	mode_t             ins_mode   = AM_IMPLIED;
	logic [LEN_W-1:0]  ins_len    = '0;
	logic [LEN_W-1:0]  seen_bytes = '0;
	logic [OPND_W-1:0] opnd_acc   = '0;
	logic              m_nar      = 1'b0;
	logic              x_nar      = 1'b0;

	// flags as the stream generator sees them
	logic gen_m = 1'b0;
	logic gen_x = 1'b0;

	code_word_t code_q[$];
	instr_t     instr_exp_q[$];
	code_word_t next_word;
	instr_t     got_instr;
	instr_t     want_instr;
	int         bytes_owed = 0;
	int         phase_bytes = 0;
	int         errors = 0;
	int         gap_pct = 0;
	int         stall_pct = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(2_000_000);
		$display("FAIL wdc816_instruction_predecoder_core");
		$finish;
	end

	function automatic dec_t decode_opcode(input logic [7:0] op, input logic m8,
		input logic x8);
		dec_t d;
		d = '{AM_IMPLIED, 3'd1};
		case (op)
			OP_ASL_A, 8'h2A, 8'h4A:                  d = '{AM_ACCUM, 3'd1};
			8'h01, 8'h21, 8'h41:                     d = '{AM_DP_X_IND, 3'd2};
			OP_BRK, OP_REP, OP_SEP:                  d = '{AM_IMM, 3'd2};
			8'h09, 8'h29, 8'h49, 8'h69, OP_LDA_IMM, OP_CMP_IMM, 8'hE9:
				d = '{AM_IMM, m8 ? 3'd2 : 3'd3};
			OP_LDY_IMM, OP_LDX_IMM, 8'hC0, 8'hE0:
				d = '{AM_IMM, x8 ? 3'd2 : 3'd3};
			8'h10, 8'h30, 8'h50, 8'h70, OP_BRA, 8'h90, 8'hB0, 8'hD0, OP_BEQ:
				d = '{AM_REL, 3'd2};
			OP_BRL:                                  d = '{AM_REL_LONG, 3'd3};
			8'h05, 8'h06, 8'h25, 8'h26, 8'h45, 8'h46,
			8'h65, 8'h85, 8'hA4, 8'hA5, 8'hA6, 8'hE5: d = '{AM_DP, 3'd2};
			8'h15, 8'h16, 8'h35, 8'h36, 8'h55,
			8'h56, 8'h75, 8'h95, 8'hB5, 8'hF5:        d = '{AM_DP_X, 3'd2};
			8'h0D, 8'h0E, 8'h20, 8'h2D, 8'h2E, 8'h4D,
			8'h4E, 8'h6D, 8'h8D, 8'hAD, 8'hED:        d = '{AM_ABS, 3'd3};
			OP_JSL:                                  d = '{AM_LONG, 3'd4};
			8'h1D, 8'h1E, 8'h3D, 8'h3E, 8'h5D,
			8'h5E, 8'h7D, 8'h9D, 8'hBD, 8'hFD:        d = '{AM_ABS_X, 3'd3};
			8'h19, 8'h39, 8'h59, 8'h79, 8'h99, 8'hB9, 8'hF9:
				d = '{AM_ABS_Y, 3'd3};
			8'h12, 8'h32, 8'h52, 8'h72, 8'h92, 8'hB2, 8'hF2:
				d = '{AM_DP_IND, 3'd2};
			8'h07, 8'h27, 8'h47, 8'h87, 8'hA7:        d = '{AM_DP_IND_LONG, 3'd2};
			8'h17, 8'h37, 8'h57, 8'h97, 8'hB7:        d = '{AM_DP_IND_LONG_Y, 3'd2};
			8'h11, 8'h31, 8'h51, 8'h91, 8'hB1:        d = '{AM_DP_IND_Y, 3'd2};
			8'h83, 8'hA3, 8'hC3:                     d = '{AM_SR, 3'd2};
			8'h93, 8'hB3:                            d = '{AM_SR_IND_Y, 3'd2};
			default:                                 d = '{AM_IMPLIED, 3'd1};
		endcase
		return d;
	endfunction

	function automatic void close_instr(input logic cut);
		instr_t r;
		logic [ADDR_W-1:0] tgt;
		tgt = '0;
		if (ins_op == OP_SEP) begin
			if ((opnd_acc[7:0] & M_BIT) != 0) m_nar = 1'b1;
			if ((opnd_acc[7:0] & X_BIT) != 0) x_nar = 1'b1;
		end else if (ins_op == OP_REP) begin
			if ((opnd_acc[7:0] & M_BIT) != 0) m_nar = 1'b0;
			if ((opnd_acc[7:0] & X_BIT) != 0) x_nar = 1'b0;
		end
		if (ins_mode == AM_REL)
			tgt = ins_addr + ADDR_W'(2) + {{(ADDR_W-8){opnd_acc[7]}}, opnd_acc[7:0]};
		else if (ins_mode == AM_REL_LONG)
			tgt = ins_addr + ADDR_W'(3) + {{(ADDR_W-16){opnd_acc[15]}}, opnd_acc[15:0]};
		r.instr_address   = ins_addr;
		r.opcode_value    = ins_op;
		r.addressing_mode = ins_mode;
		r.instr_length    = ins_len;
		r.operand_value   = opnd_acc;
		r.branch_target   = tgt;
		r.truncated       = cut;
		r.accum_narrow    = m_nar;
		r.index_narrow    = x_nar;
		instr_exp_q.push_back(r);
		seen_bytes = '0;
	endfunction

	function automatic void track_byte(input logic [7:0] b, input logic last);
		dec_t d;
		if (seen_bytes == 0) begin
			d = decode_opcode(b, m_nar, x_nar);
			ins_addr   = next_addr;
			ins_op     = b;
			ins_mode   = d.mode;
			ins_len    = d.len;
			opnd_acc   = '0;
			seen_bytes = 3'd1;
			if (ins_len <= 1) close_instr(1'b0);
			else if (last) close_instr(1'b1);
		end else begin
			opnd_acc   = opnd_acc | (OPND_W'(b) << (8 * (seen_bytes - 1)));
			seen_bytes = seen_bytes + 3'd1;
			if (seen_bytes >= ins_len) close_instr(1'b0);
			else if (last) close_instr(1'b1);
		end
		next_addr = next_addr + ADDR_W'(1);
		if (last) begin
			next_addr  = base_addr;
			seen_bytes = '0;
		end
	endfunction

	function automatic string show(input instr_t r);
		return $sformatf("addr %h op %h mode %0d len %0d opnd %h tgt %h trunc %b m %b x %b",
			r.instr_address, r.opcode_value, r.addressing_mode, r.instr_length,
			r.operand_value, r.branch_target, r.truncated, r.accum_narrow,
			r.index_narrow);
	endfunction

	// byte driver
	always @(posedge clk) begin
		if (!arst_n) begin
			code_ch.valid <= 1'b0;
		end else begin
			if (code_ch.valid && code_ch.ready) begin
				track_byte(code_ch.code_byte, code_ch.last_byte);
				bytes_owed--;
			end
			if (!code_ch.valid || code_ch.ready) begin
				if (code_q.size() != 0 && !(gap_pct != 0 && $urandom_range(99) < gap_pct)) begin
					next_word = code_q.pop_front();
					code_ch.valid     <= 1'b1;
					code_ch.code_byte <= next_word.b;
					code_ch.last_byte <= next_word.last;
				end else begin
					code_ch.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			instr_ch.ready <= 1'b0;
		end else begin
			instr_ch.ready <= !(stall_pct != 0 && $urandom_range(99) < stall_pct);
			if (instr_ch.valid && instr_ch.ready) begin
				got_instr.instr_address   = instr_ch.instr_address;
				got_instr.opcode_value    = instr_ch.opcode_value;
				got_instr.addressing_mode = instr_ch.addressing_mode;
				got_instr.instr_length    = instr_ch.instr_length;
				got_instr.operand_value   = instr_ch.operand_value;
				got_instr.branch_target   = instr_ch.branch_target;
				got_instr.truncated       = instr_ch.truncated;
				got_instr.accum_narrow    = instr_ch.accum_narrow;
				got_instr.index_narrow    = instr_ch.index_narrow;
				if (instr_exp_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected word: %s", show(got_instr));
				end else begin
					want_instr = instr_exp_q.pop_front();
					if (got_instr !== want_instr) begin
						errors++;
						if (errors <= 10) begin
							$display("mismatch expected: %s", show(want_instr));
							$display("         actual:   %s", show(got_instr));
						end
					end
				end
			end
		end
	end

	task automatic push_code(input logic [7:0] b, input logic last);
		code_q.push_back('{b, last});
		bytes_owed++;
		phase_bytes++;
	endtask

	task automatic push_instr(input logic [7:0] op, input logic [23:0] opnd,
		input int n, input logic last);
		push_code(op, last && n == 1);
		for (int k = 1; k < n; k++)
			push_code(opnd[8*(k-1) +: 8], last && k == n - 1);
	endtask

	task automatic add_section(input int n_instr);
		logic [7:0] op;
		logic [7:0] b;
		dec_t d;
		int n;
		logic fin;
		for (int i = 0; i < n_instr; i++) begin
			case ($urandom_range(19))
				0, 1, 2: op = OP_SEP;
				3, 4:    op = OP_REP;
				5:       op = OP_LDA_IMM;
				6:       op = OP_LDX_IMM;
				7:       op = OP_LDY_IMM;
				8:       op = OP_CMP_IMM;
				9:       op = OP_BRA;
				10:      op = OP_BEQ;
				11:      op = OP_BRL;
				12:      op = OP_JSL;
				default: op = 8'($urandom_range(255));
			endcase
			d = decode_opcode(op, gen_m, gen_x);
			fin = (i == n_instr - 1);
			n = int'(d.len);
			if (fin && n > 1 && $urandom_range(3) == 0)
				n = $urandom_range(n - 1, 1);
			push_code(op, fin && n == 1);
			for (int k = 1; k < n; k++) begin
				b = 8'($urandom_range(255));
				push_code(b, fin && k == n - 1);
				if (n == d.len && op == OP_SEP) begin
					if ((b & M_BIT) != 0) gen_m = 1'b1;
					if ((b & X_BIT) != 0) gen_x = 1'b1;
				end else if (n == d.len && op == OP_REP) begin
					if ((b & M_BIT) != 0) gen_m = 1'b0;
					if ((b & X_BIT) != 0) gen_x = 1'b0;
				end
			end
		end
	endtask

	task automatic write_base(input logic [ADDR_W-1:0] a);
		@(posedge clk);
		cfg_ch.valid        <= 1'b1;
		cfg_ch.base_address <= a;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		base_addr = a;
		next_addr = a;
	endtask

	task automatic drain();
		while (bytes_owed != 0 || instr_exp_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		arst_n               = 1'b0;
		code_ch.valid        = 1'b0;
		code_ch.code_byte    = '0;
		code_ch.last_byte    = 1'b0;
		instr_ch.ready       = 1'b0;
		cfg_ch.valid         = 1'b0;
		cfg_ch.base_address  = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// wide immediates out of reset, then width flags, branches, cut-off sections
		push_instr(OP_LDA_IMM, 24'h001234, 3, 1'b0);
		push_instr(OP_LDX_IMM, 24'h00ABCD, 3, 1'b0);
		push_instr(OP_SEP, 24'h000030, 2, 1'b0);
		push_instr(OP_LDA_IMM, 24'h000080, 2, 1'b0);
		push_instr(OP_LDY_IMM, 24'h0000FF, 2, 1'b0);
		push_instr(OP_REP, 24'h000020, 2, 1'b0);
		push_instr(OP_BRA, 24'h000080, 2, 1'b0);
		push_instr(OP_BRL, 24'h007FFF, 3, 1'b0);
		push_instr(OP_UNLISTED, 24'h0, 1, 1'b0);
		push_instr(OP_ASL_A, 24'h0, 1, 1'b0);
		push_instr(OP_JSL, 24'h0000AB, 2, 1'b1);
		push_instr(OP_SEP, 24'h0, 1, 1'b1);
		drain();
		gen_m = m_nar;
		gen_x = x_nar;

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					gap_pct = 0;  stall_pct = 0;  write_base('1);
				end
				1: begin
					gap_pct = 45; stall_pct = 0;  write_base('0);
				end
				2: begin
					gap_pct = 0;  stall_pct = 45; write_base(ADDR_W'($urandom));
				end
				default: begin
					gap_pct = 36; stall_pct = 36; write_base(24'hFFFFF8);
				end
			endcase
			phase_bytes = 0;
			while (phase_bytes < 120) add_section($urandom_range(10, 1));
			drain();
		end

		if (errors == 0) begin
			$display("PASS wdc816_instruction_predecoder_core");
		end else begin
			$display("FAIL wdc816_instruction_predecoder_core");
		end
		$finish;
	end

endmodule
